// ===== rtl/scru_pkg.sv =====
// Package for the sequenced calculator request unit: codes, sizes and types.
// No dependencies.
package scru_pkg;

  localparam int SeqBitsDefault = 32;
  localparam int SeqFieldBits   = 32;
  localparam int ValBits        = 64;

  localparam logic [1:0] CMD_ACK  = 2'd0;
  localparam logic [1:0] CMD_MATH = 2'd1;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_FACT = 3'd4;
  localparam logic [2:0] OP_SQRT = 3'd5;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_RESP = 2'd1;
  localparam logic [1:0] KIND_HARD = 2'd2;

  localparam logic [1:0] ST_FAST = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_HARD = 2'd2;

  // input tdata: cmd, seq_num, op_code, operand_a, operand_b = 165 bits -> 168
  localparam int InBits  = 168;
  // output tdata: kind, out_seq, status, value = 100 bits -> 104
  localparam int OutBits = 104;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_FACT, S_SQRT, S_ACK, S_RESP, S_HARD
  } state_t;

endpackage

// ===== rtl/sequenced_calculator_request_unit.sv =====
// Top level of the sequenced calculator request unit; depends on scru_pkg.
// A resend gives only an ack; a new request gives an ack and a response, then a hard
// result for factorial (zero for n>=66) or square root (zero if negative); every result
// is held while the consumer stalls.
// One request at a time; division and square root share the shift/add/subtract unit.
// Reset (rst, synchronous) clears the sequence counters and the ack flag.
module sequenced_calculator_request_unit #(
  parameter int SEQ_BITS = scru_pkg::SeqBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // cmd[1:0], seq_num[33:2], op_code[36:34], operand_a[100:37],
  // operand_b[164:101], zeros above
  input  logic [scru_pkg::InBits-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // kind[1:0], out_seq[33:2], status[35:34], value[99:36], zeros above
  output logic [scru_pkg::OutBits-1:0] m_tdata,
  output logic m_tlast
);
  import scru_pkg::*;

  state_t state, state_next;

  logic [SEQ_BITS-1:0] expected_request, response_count;
  logic                ack_seen;

  // request registers
  logic [SEQ_BITS-1:0] seq;
  logic [ValBits-1:0]  a, b;
  logic [1:0]          status;
  logic [ValBits-1:0]  value, hard;
  logic                resend;

  // shared iterative unit registers
  logic [ValBits-1:0]  acc, rem, quo, cnt64;
  logic [6:0]          step;
  logic                neg_q;

  logic [1:0]          in_cmd;
  logic [SEQ_BITS-1:0] in_seq;
  assign in_cmd = s_tdata[1:0];
  // only the low SEQ_BITS bits of the 32-bit number take part
  assign in_seq = SEQ_BITS'({{ValBits{1'b0}}, s_tdata[33:2]});

  logic                accept, out_fire;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  // shared unit: one subtraction per step; division shifts the remainder first
  logic [ValBits:0]   sub_r;
  logic [ValBits-1:0] rem_sh;
  logic [ValBits-1:0] trial;
  always_comb begin
    rem_sh = {rem[ValBits-2:0], quo[ValBits-1]};
    trial  = (state == S_SQRT) ? (acc | cnt64) : b;
    if (state == S_SQRT) sub_r = {1'b0, rem} - {1'b0, trial};
    else                 sub_r = {1'b0, rem_sh} - {1'b0, trial};
  end

  // factorial step: acc * cnt with cnt < 66, done as 7 shifted adds
  logic [ValBits-1:0] fprod;
  always_comb begin
    fprod = '0;
    for (int i = 0; i < 7; i++)
      if (cnt64[i]) fprod = fprod + (acc << i);
  end

  // multiply step: 4 bits of b per cycle
  logic [ValBits-1:0] mpart;
  always_comb begin
    mpart = '0;
    for (int i = 0; i < 4; i++)
      if (b[i]) mpart = mpart + (a << i);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && in_cmd == CMD_MATH && in_seq <= expected_request) begin
          state_next = S_ACK;
          if (in_seq == expected_request) begin
            unique case (s_tdata[36:34])
              OP_MUL:  state_next = S_MUL;
              OP_DIV:  state_next = (s_tdata[164:101] == '0) ? S_ACK : S_DIV;
              OP_FACT: state_next = S_FACT;
              OP_SQRT: state_next = S_SQRT;
              default: state_next = S_ACK;
            endcase
          end
        end
      end
      S_MUL:  if (step == 7'd15) state_next = S_ACK;
      S_DIV:  if (step == 7'd63) state_next = S_ACK;
      S_FACT: if (cnt64 >= a || a >= 64'd66) state_next = S_ACK;
      // a negative operand finishes at once with a zero root
      S_SQRT: if (a[ValBits-1] || cnt64 == '0 || step == 7'd31) state_next = S_ACK;
      S_ACK:  if (out_fire) state_next = resend ? S_IDLE : S_RESP;
      S_RESP: if (out_fire) state_next = (status == ST_HARD) ? S_HARD : S_IDLE;
      S_HARD: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_request <= '0;
      response_count   <= '0;
      ack_seen         <= 1'b0;
    end else begin
      if (accept && in_cmd == CMD_ACK && in_seq == response_count - 1'b1)
        ack_seen <= 1'b1;
      if (state == S_ACK && out_fire && !resend)
        expected_request <= expected_request + 1'b1;
      if ((state == S_RESP || state == S_HARD) && out_fire)
        response_count <= response_count + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        seq    <= in_seq;
        a      <= s_tdata[100:37];
        b      <= s_tdata[164:101];
        resend <= (in_seq != expected_request);
        step   <= '0;
        status <= ST_FAST;
        value  <= '0;
        hard   <= '0;
        acc    <= 64'd1;
        cnt64  <= 64'd1;
        rem    <= '0;
        unique case (s_tdata[36:34])
          OP_ADD: value <= s_tdata[100:37] + s_tdata[164:101];
          OP_SUB: value <= s_tdata[100:37] - s_tdata[164:101];
          OP_MUL: acc <= '0;
          OP_DIV: begin
            if (s_tdata[164:101] == '0) status <= ST_BAD;
            neg_q <= s_tdata[100] ^ s_tdata[164];
            quo   <= s_tdata[100] ? -s_tdata[100:37] : s_tdata[100:37];
            b     <= s_tdata[164] ? -s_tdata[164:101] : s_tdata[164:101];
          end
          OP_FACT: status <= ST_HARD;
          OP_SQRT: begin
            status <= ST_HARD;
            acc    <= '0;
            rem    <= s_tdata[100:37];
            cnt64  <= 64'h4000_0000_0000_0000;
          end
          default: status <= ST_BAD;
        endcase
      end
      S_MUL: begin
        acc  <= acc + mpart;
        a    <= a << 4;
        b    <= b >> 4;
        step <= step + 1'b1;
        if (step == 7'd15) value <= acc + mpart;
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!sub_r[ValBits]) begin
          rem <= sub_r[ValBits-1:0];
          quo <= {quo[ValBits-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[ValBits-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == 7'd63)
          value <= neg_q ? -{quo[ValBits-2:0], !sub_r[ValBits]}
                         : {quo[ValBits-2:0], !sub_r[ValBits]};
      end
      S_FACT: begin
        if (a >= 64'd66)      hard <= '0;
        else if (cnt64 >= a)  hard <= acc;
        else begin
          acc   <= fprod + acc; // acc * (cnt+1)
          cnt64 <= cnt64 + 1'b1;
        end
      end
      S_SQRT: begin
        // bit-pair square root, one result bit per cycle
        if (a[ValBits-1]) begin
          hard <= '0;
        end else begin
          if (!sub_r[ValBits]) begin
            rem <= sub_r[ValBits-1:0];
            acc <= (acc >> 1) + cnt64;
            if (cnt64[1:0] != 2'b00 || step == 7'd31) hard <= (acc >> 1) + cnt64;
          end else begin
            acc <= acc >> 1;
            if (cnt64[1:0] != 2'b00 || step == 7'd31) hard <= acc >> 1;
          end
          cnt64 <= cnt64 >> 2;
          step  <= step + 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic [1:0]          o_kind, o_status;
  logic [SEQ_BITS-1:0] o_seq;
  logic [ValBits-1:0]  o_value;
  always_comb begin
    o_kind   = KIND_ACK;
    o_status = ST_FAST;
    o_seq    = seq;
    o_value  = '0;
    m_tlast  = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      S_ACK: begin
        m_tvalid = 1'b1;
        m_tlast  = resend;
      end
      S_RESP: begin
        m_tvalid = 1'b1;
        o_kind   = KIND_RESP;
        o_seq    = response_count;
        o_status = status;
        o_value  = value;
        m_tlast  = (status != ST_HARD);
      end
      S_HARD: begin
        m_tvalid = 1'b1;
        o_kind   = KIND_HARD;
        o_seq    = response_count;
        o_value  = hard;
        m_tlast  = 1'b1;
      end
      default: ;
    endcase
  end

  logic [SeqFieldBits-1:0] o_seq32;
  assign o_seq32 = SeqFieldBits'({{64{1'b0}}, o_seq});
  assign m_tdata = {4'b0, o_value, o_status, o_seq32, o_kind};

endmodule

// ===== rtl/scru_checker.sv =====
// Port-level checker for the sequenced calculator request unit, with its bind.
// Depends on scru_pkg.
module scru_checker (
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [scru_pkg::OutBits-1:0] m_tdata,
  input logic m_tlast
);
  import scru_pkg::*;

  // never take a request while a result is on offer
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("ready with result pending");

  // a held result stays stable
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a hard result always ends its run
  a_hard: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == KIND_HARD |-> m_tlast)
    else $error("hard result not last");

  // an ack is followed by a response unless it ends the run
  a_ack: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[1:0] == KIND_ACK && !m_tlast
      |=> m_tvalid && m_tdata[1:0] == KIND_RESP)
    else $error("ack without response");

endmodule

bind sequenced_calculator_request_unit scru_checker u_scru_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
